// ===== rtl/tch_pkg.sv =====
// Shared types, widths, constants and helper functions of the tilt-compensated heading block.
`default_nettype none

package tch_pkg;

    // Sample width of every sensor field and of the min/max calibration registers.
    localparam int SAMPLE_WIDTH = 16;
    localparam int OFFSET_WIDTH = 9;
    localparam int HEADING_W    = 16;

    // Hard-iron corrected magnetometer: 2*field - (min + max).
    localparam int MAG_W   = SAMPLE_WIDTH + 2;
    // Vectors are reduced below 2^RED_B before the cross products.
    localparam int RED_B   = 20;
    localparam int RED_W   = RED_B + 1;
    localparam int PROD_W  = 2 * RED_W;
    localparam int E_W     = PROD_W + 1;
    localparam int ER_B    = 30;
    localparam int ER_W    = ER_B + 1;
    localparam int ASQ_W   = 2 * RED_B + 2;
    localparam int SQ_IN_W = ASQ_W + 16;
    localparam int SQ_W    = SQ_IN_W / 2;
    localparam int PX_W    = SQ_W + 1 + ER_W;
    localparam int PY_W    = RED_W + ER_W;
    localparam int XY_W    = 60;

    // CORDIC datapath; angles in 1/25600 degree.
    localparam int CORDIC_STEPS = 20;
    localparam int XYR_B        = 30;
    localparam int CX_W         = 34;
    localparam int Z_W          = 26;
    localparam int Z_180        = 180 * 25600;
    localparam int Z_360        = 360 * 25600;
    localparam int DEG_180      = 18000;
    localparam int DEG_360      = 36000;
    localparam int COR_W        = 18;

    // APB register map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_MAG_MIN_X,
        REG_MAG_MIN_Y,
        REG_MAG_MIN_Z,
        REG_MAG_MAX_X,
        REG_MAG_MAX_Y,
        REG_MAG_MAX_Z,
        REG_HEADING_OFFSET
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] field_x;
        logic signed [SAMPLE_WIDTH-1:0] field_y;
        logic signed [SAMPLE_WIDTH-1:0] field_z;
        logic signed [SAMPLE_WIDTH-1:0] accel_x;
        logic signed [SAMPLE_WIDTH-1:0] accel_y;
        logic signed [SAMPLE_WIDTH-1:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic [HEADING_W-1:0] heading_raw;
        logic [HEADING_W-1:0] heading_corrected;
        logic                 degenerate;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] mag_min_x;
        logic signed [SAMPLE_WIDTH-1:0] mag_min_y;
        logic signed [SAMPLE_WIDTH-1:0] mag_min_z;
        logic signed [SAMPLE_WIDTH-1:0] mag_max_x;
        logic signed [SAMPLE_WIDTH-1:0] mag_max_y;
        logic signed [SAMPLE_WIDTH-1:0] mag_max_z;
        logic signed [OFFSET_WIDTH-1:0] heading_offset_deg;
    } t_cfg;

    // Reduced east vector plus what the heading still needs from the accelerometer.
    typedef struct packed {
        logic signed [ER_W-1:0]  ex;
        logic signed [ER_W-1:0]  ey;
        logic signed [ER_W-1:0]  ez;
        logic signed [RED_W-1:0] ax;
        logic signed [RED_W-1:0] az;
        logic                    degen;
    } t_front;

    function automatic logic [63:0] absv(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Shift count that brings the largest magnitude below 2^b.
    function automatic logic [6:0] red_shift(input logic [63:0] ormag, input int b);
        logic [6:0] k;
        k = '0;
        for (int p = 0; p < 64; p++) begin
            if (ormag[p] && p >= b) begin
                k = 7'(p - b + 1);
            end
        end
        return k;
    endfunction

    // Arithmetic shift right, truncating toward zero.
    function automatic logic signed [63:0] shr0(input logic signed [63:0] v,
                                                input logic [6:0] k);
        logic [63:0] s;
        s = absv(v) >> k;
        return v[63] ? -signed'(s) : signed'(s);
    endfunction

    function automatic int atan_entry(input int i);
        int r;
        unique case (i)
            0:       r = 1152000;
            1:       r = 680065;
            2:       r = 359328;
            3:       r = 182400;
            4:       r = 91554;
            5:       r = 45822;
            6:       r = 22916;
            7:       r = 11459;
            8:       r = 5730;
            9:       r = 2865;
            10:      r = 1432;
            11:      r = 716;
            12:      r = 358;
            13:      r = 179;
            14:      r = 90;
            15:      r = 45;
            16:      r = 22;
            17:      r = 11;
            18:      r = 6;
            19:      r = 3;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tch_front.sv =====
// Front pipeline: hard-iron removal, vector reduction, cross product east = m x a, |a|^2.
`default_nettype none

module tch_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire tch_pkg::t_in_item i_item,
    input  wire tch_pkg::t_cfg     i_cfg,
    output logic                   o_valid,
    output tch_pkg::t_front        o_data,
    output logic [tch_pkg::ASQ_W-1:0] o_asq
);

    localparam int MW = tch_pkg::MAG_W;
    localparam int SW = tch_pkg::SAMPLE_WIDTH;
    localparam int RW = tch_pkg::RED_W;
    localparam int PW = tch_pkg::PROD_W;
    localparam int EW = tch_pkg::E_W;
    localparam int AW = tch_pkg::ASQ_W;

    // stage 1: twice the offset-corrected magnetometer
    logic                 r_v1;
    logic signed [MW-1:0] r_mx, r_my, r_mz;
    logic signed [SW-1:0] r_ax1, r_ay1, r_az1;

    // stage 2: reduced vectors
    logic                 r_v2;
    logic signed [RW-1:0] r_mx2, r_my2, r_mz2, r_ax2, r_ay2, r_az2;
    logic signed [RW-1:0] n_mx2, n_my2, n_mz2, n_ax2, n_ay2, n_az2;

    // stage 3: products
    logic                 r_v3;
    logic signed [PW-1:0] r_myaz, r_mzay, r_mzax, r_mxaz, r_mxay, r_myax;
    logic signed [PW-1:0] r_sqx, r_sqy, r_sqz;
    logic signed [RW-1:0] r_ax3, r_az3;

    // stage 4: east vector and |a|^2
    logic                 r_v4;
    logic signed [EW-1:0] r_ex, r_ey, r_ez;
    logic [AW-1:0]        r_asq4;
    logic signed [RW-1:0] r_ax4, r_az4;
    logic                 r_degen4;

    // stage 5: reduced east vector
    logic                 r_v5;
    tch_pkg::t_front      r_out;
    tch_pkg::t_front      n_out;
    logic [AW-1:0]        r_asq5;

    logic [6:0] km, ka, ke;
    logic signed [EW-1:0] n_ex, n_ey, n_ez;

    always_comb begin
        km = tch_pkg::red_shift(tch_pkg::absv(64'(r_mx)) | tch_pkg::absv(64'(r_my)) |
                                tch_pkg::absv(64'(r_mz)), tch_pkg::RED_B);
        ka = tch_pkg::red_shift(tch_pkg::absv(64'(r_ax1)) | tch_pkg::absv(64'(r_ay1)) |
                                tch_pkg::absv(64'(r_az1)), tch_pkg::RED_B);
        n_mx2 = RW'(tch_pkg::shr0(64'(r_mx), km));
        n_my2 = RW'(tch_pkg::shr0(64'(r_my), km));
        n_mz2 = RW'(tch_pkg::shr0(64'(r_mz), km));
        n_ax2 = RW'(tch_pkg::shr0(64'(r_ax1), ka));
        n_ay2 = RW'(tch_pkg::shr0(64'(r_ay1), ka));
        n_az2 = RW'(tch_pkg::shr0(64'(r_az1), ka));
    end

    always_comb begin
        n_ex = EW'(r_myaz) - EW'(r_mzay);
        n_ey = EW'(r_mzax) - EW'(r_mxaz);
        n_ez = EW'(r_mxay) - EW'(r_myax);
    end

    always_comb begin
        ke = tch_pkg::red_shift(tch_pkg::absv(64'(r_ex)) | tch_pkg::absv(64'(r_ey)) |
                                tch_pkg::absv(64'(r_ez)), tch_pkg::ER_B);
        n_out.ex    = tch_pkg::ER_W'(tch_pkg::shr0(64'(r_ex), ke));
        n_out.ey    = tch_pkg::ER_W'(tch_pkg::shr0(64'(r_ey), ke));
        n_out.ez    = tch_pkg::ER_W'(tch_pkg::shr0(64'(r_ez), ke));
        n_out.ax    = r_ax4;
        n_out.az    = r_az4;
        n_out.degen = r_degen4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx  <= (MW'(i_item.field_x) <<< 1) - (MW'(i_cfg.mag_min_x) + MW'(i_cfg.mag_max_x));
        r_my  <= (MW'(i_item.field_y) <<< 1) - (MW'(i_cfg.mag_min_y) + MW'(i_cfg.mag_max_y));
        r_mz  <= (MW'(i_item.field_z) <<< 1) - (MW'(i_cfg.mag_min_z) + MW'(i_cfg.mag_max_z));
        r_ax1 <= i_item.accel_x;
        r_ay1 <= i_item.accel_y;
        r_az1 <= i_item.accel_z;

        r_mx2 <= n_mx2;
        r_my2 <= n_my2;
        r_mz2 <= n_mz2;
        r_ax2 <= n_ax2;
        r_ay2 <= n_ay2;
        r_az2 <= n_az2;

        r_myaz <= PW'(r_my2 * r_az2);
        r_mzay <= PW'(r_mz2 * r_ay2);
        r_mzax <= PW'(r_mz2 * r_ax2);
        r_mxaz <= PW'(r_mx2 * r_az2);
        r_mxay <= PW'(r_mx2 * r_ay2);
        r_myax <= PW'(r_my2 * r_ax2);
        r_sqx  <= PW'(r_ax2 * r_ax2);
        r_sqy  <= PW'(r_ay2 * r_ay2);
        r_sqz  <= PW'(r_az2 * r_az2);
        r_ax3  <= r_ax2;
        r_az3  <= r_az2;

        r_ex     <= n_ex;
        r_ey     <= n_ey;
        r_ez     <= n_ez;
        r_asq4   <= AW'(r_sqx) + AW'(r_sqy) + AW'(r_sqz);
        r_ax4    <= r_ax3;
        r_az4    <= r_az3;
        r_degen4 <= (n_ex == '0) && (n_ey == '0) && (n_ez == '0);

        r_out  <= n_out;
        r_asq5 <= r_asq4;
    end

    assign o_valid = r_v5;
    assign o_data  = r_out;
    assign o_asq   = r_asq5;

endmodule

`default_nettype wire

// ===== rtl/tch_isqrt.sv =====
// Pipelined integer square root of |a|^2 * 65536, one result bit per stage.
`default_nettype none

module tch_isqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire tch_pkg::t_front           i_side,
    input  wire logic [tch_pkg::ASQ_W-1:0] i_asq,
    output logic                           o_valid,
    output tch_pkg::t_front                o_side,
    output logic [tch_pkg::SQ_W-1:0]       o_root
);

    localparam int IW = tch_pkg::SQ_IN_W;
    localparam int N  = tch_pkg::SQ_W;

    logic            r_val  [0:N];
    logic [IW-1:0]   r_rem  [0:N];
    logic [IW-1:0]   r_root [0:N];
    tch_pkg::t_front r_side [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val[0] <= 1'b0;
        end else begin
            r_val[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= {i_asq, 16'd0};
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar j = 1; j <= N; j++) begin : g_step
        localparam logic [IW-1:0] BIT = IW'(1) << (2 * (N - j));
        logic [IW:0]   trial;
        logic [IW-1:0] n_rem, n_root;

        always_comb begin
            trial = {1'b0, r_root[j-1]} + {1'b0, BIT};
            if ({1'b0, r_rem[j-1]} >= trial) begin
                n_rem  = r_rem[j-1] - trial[IW-1:0];
                n_root = (r_root[j-1] >> 1) + BIT;
            end else begin
                n_rem  = r_rem[j-1];
                n_root = r_root[j-1] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[j] <= 1'b0;
            end else begin
                r_val[j] <= r_val[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_rem;
            r_root[j] <= n_root;
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_valid = r_val[N];
    assign o_side  = r_side[N];
    assign o_root  = r_root[N][N-1:0];

endmodule

`default_nettype wire

// ===== rtl/tch_cordic.sv =====
// Vectoring CORDIC pipeline: atan2(Y, X) in hundredths of a degree, 0..36000.
`default_nettype none

module tch_cordic (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic signed [tch_pkg::XY_W-1:0] i_x,
    input  wire logic signed [tch_pkg::XY_W-1:0] i_y,
    input  wire logic                            i_degen,
    output logic                                 o_valid,
    output logic [tch_pkg::HEADING_W-1:0]        o_heading,
    output logic                                 o_degen
);

    localparam int XW = tch_pkg::XY_W;
    localparam int CW = tch_pkg::CX_W;
    localparam int ZW = tch_pkg::Z_W;
    localparam int N  = tch_pkg::CORDIC_STEPS;

    typedef struct packed {
        logic yzero;
        logic xneg;
        logic degen;
    } t_flags;

    // stage A: shift count of the joint reduction
    logic                 r_va;
    logic signed [XW-1:0] r_xa, r_ya;
    logic [6:0]           r_ka;
    t_flags               r_fa;

    // CORDIC stages; index 0 holds the reduced, pre-rotated vector
    logic                 r_val [0:N];
    logic signed [CW-1:0] r_x   [0:N];
    logic signed [CW-1:0] r_y   [0:N];
    logic signed [ZW-1:0] r_z   [0:N];
    t_flags               r_f   [0:N];

    logic signed [CW-1:0] n_xs, n_ys;

    // output stage
    logic                              r_vo;
    logic [tch_pkg::HEADING_W-1:0]     r_head;
    logic                              r_degen;
    logic signed [ZW-1:0]              zfix;
    logic [ZW-1:0]                     zrnd;
    logic [tch_pkg::HEADING_W-1:0]     n_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va     <= 1'b0;
            r_val[0] <= 1'b0;
            r_vo     <= 1'b0;
        end else begin
            r_va     <= i_valid;
            r_val[0] <= r_va;
            r_vo     <= r_val[N];
        end
    end

    always_comb begin
        n_xs = CW'(tch_pkg::shr0(64'(r_xa), r_ka));
        n_ys = CW'(tch_pkg::shr0(64'(r_ya), r_ka));
    end

    always_ff @(posedge i_clk) begin
        r_xa     <= i_x;
        r_ya     <= i_y;
        r_ka     <= tch_pkg::red_shift(tch_pkg::absv(64'(i_x)) | tch_pkg::absv(64'(i_y)),
                                       tch_pkg::XYR_B);
        r_fa     <= '{yzero: (i_y == '0), xneg: i_x[XW-1], degen: i_degen};

        // left half-plane after the reduction: rotate by 180 degrees first
        if (n_xs[CW-1]) begin
            r_x[0] <= -n_xs;
            r_y[0] <= -n_ys;
            r_z[0] <= ZW'(tch_pkg::Z_180);
        end else begin
            r_x[0] <= n_xs;
            r_y[0] <= n_ys;
            r_z[0] <= '0;
        end
        r_f[0] <= r_fa;
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [ZW-1:0] ANG = ZW'(tch_pkg::atan_entry(i));
        logic signed [CW-1:0] xs, ys;

        always_comb begin
            xs = CW'(tch_pkg::shr0(64'(r_x[i]), 7'(i)));
            ys = CW'(tch_pkg::shr0(64'(r_y[i]), 7'(i)));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[i+1] <= 1'b0;
            end else begin
                r_val[i+1] <= r_val[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + ANG;
            end else begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - ANG;
            end
            r_f[i+1] <= r_f[i];
        end
    end

    always_comb begin
        zfix = r_z[N][ZW-1] ? r_z[N] + ZW'(tch_pkg::Z_360) : r_z[N];
        zrnd = ZW'(zfix) + ZW'(128);
        priority if (r_f[N].degen) begin
            n_head = '0;
        end else if (r_f[N].yzero) begin
            n_head = r_f[N].xneg ? tch_pkg::HEADING_W'(tch_pkg::DEG_180) : '0;
        end else begin
            n_head = zrnd[tch_pkg::HEADING_W+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_degen <= r_f[N].degen;
    end

    assign o_valid   = r_vo;
    assign o_heading = r_head;
    assign o_degen   = r_degen;

endmodule

`default_nettype wire

// ===== rtl/tilt_compensated_heading.sv =====
// Top level of the tilt-compensated heading block: register port, pipeline glue, correction.
`default_nettype none

// Fully pipelined: one sample pair may be started every clock cycle and busy
// never rises. Each result shows on o_result with o_done high for one cycle,
// after 5 front stages, 30 square-root stages: one load stage and one per root
// bit, 2 multiply stages, 23 CORDIC stages with 20 iterations and one output
// stage; results leave in start order and cannot be held off. Configuration
// registers are sampled as items pass, so write them only while no
// transaction is in flight.

module tilt_compensated_heading (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire tch_pkg::t_in_item               i_item,
    output logic                                 o_done,
    output tch_pkg::t_out_item                   o_result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tch_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [tch_pkg::PDATA_W-1:0]     pwdata,
    output logic [tch_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int SW = tch_pkg::SAMPLE_WIDTH;
    localparam int OW = tch_pkg::OFFSET_WIDTH;
    localparam int CR = tch_pkg::COR_W;

    tch_pkg::t_cfg    r_cfg;
    tch_pkg::t_reg_idx reg_idx;

    logic                                  front_valid;
    tch_pkg::t_front                       front_data;
    logic [tch_pkg::ASQ_W-1:0]             front_asq;
    logic                                  sq_valid;
    tch_pkg::t_front                       sq_side;
    logic [tch_pkg::SQ_W-1:0]              sq_root;

    logic                                  r_vp;
    logic signed [tch_pkg::PX_W-1:0]       r_px;
    logic signed [tch_pkg::PY_W-1:0]       r_pzx, r_pxz;
    logic                                  r_degp;
    logic                                  r_vxy;
    logic signed [tch_pkg::XY_W-1:0]       r_x, r_y;
    logic                                  r_degxy;
    logic signed [tch_pkg::PY_W:0]         dy;

    logic                                  cd_valid;
    logic [tch_pkg::HEADING_W-1:0]         cd_head;
    logic                                  cd_degen;

    logic signed [CR-1:0]                  cor;
    logic signed [CR-1:0]                  cor_wrap;
    logic                                  r_done;
    tch_pkg::t_out_item                    r_res;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign reg_idx = tch_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                tch_pkg::REG_MAG_MIN_X:      r_cfg.mag_min_x <= pwdata[SW-1:0];
                tch_pkg::REG_MAG_MIN_Y:      r_cfg.mag_min_y <= pwdata[SW-1:0];
                tch_pkg::REG_MAG_MIN_Z:      r_cfg.mag_min_z <= pwdata[SW-1:0];
                tch_pkg::REG_MAG_MAX_X:      r_cfg.mag_max_x <= pwdata[SW-1:0];
                tch_pkg::REG_MAG_MAX_Y:      r_cfg.mag_max_y <= pwdata[SW-1:0];
                tch_pkg::REG_MAG_MAX_Z:      r_cfg.mag_max_z <= pwdata[SW-1:0];
                tch_pkg::REG_HEADING_OFFSET: r_cfg.heading_offset_deg <= pwdata[OW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tch_pkg::REG_MAG_MIN_X:      prdata = tch_pkg::PDATA_W'(r_cfg.mag_min_x);
            tch_pkg::REG_MAG_MIN_Y:      prdata = tch_pkg::PDATA_W'(r_cfg.mag_min_y);
            tch_pkg::REG_MAG_MIN_Z:      prdata = tch_pkg::PDATA_W'(r_cfg.mag_min_z);
            tch_pkg::REG_MAG_MAX_X:      prdata = tch_pkg::PDATA_W'(r_cfg.mag_max_x);
            tch_pkg::REG_MAG_MAX_Y:      prdata = tch_pkg::PDATA_W'(r_cfg.mag_max_y);
            tch_pkg::REG_MAG_MAX_Z:      prdata = tch_pkg::PDATA_W'(r_cfg.mag_max_z);
            tch_pkg::REG_HEADING_OFFSET: prdata = tch_pkg::PDATA_W'(r_cfg.heading_offset_deg);
            default:                     prdata = '0;
        endcase
    end

    tch_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (front_valid),
        .o_data  (front_data),
        .o_asq   (front_asq)
    );

    tch_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_side  (front_data),
        .i_asq   (front_asq),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    // X = sqrt(|a|^2 * 65536) * e.y, Y = 256 * (a.z*e.x - a.x*e.z)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp  <= 1'b0;
            r_vxy <= 1'b0;
        end else begin
            r_vp  <= sq_valid;
            r_vxy <= r_vp;
        end
    end

    assign dy = (tch_pkg::PY_W+1)'(r_pzx) - (tch_pkg::PY_W+1)'(r_pxz);

    always_ff @(posedge i_clk) begin
        r_px    <= tch_pkg::PX_W'(signed'({1'b0, sq_root}) * sq_side.ey);
        r_pzx   <= tch_pkg::PY_W'(sq_side.az * sq_side.ex);
        r_pxz   <= tch_pkg::PY_W'(sq_side.ax * sq_side.ez);
        r_degp  <= sq_side.degen;
        r_x     <= tch_pkg::XY_W'(r_px);
        r_y     <= tch_pkg::XY_W'(signed'({dy, 8'd0}));
        r_degxy <= r_degp;
    end

    tch_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vxy),
        .i_x       (r_x),
        .i_y       (r_y),
        .i_degen   (r_degxy),
        .o_valid   (cd_valid),
        .o_heading (cd_head),
        .o_degen   (cd_degen)
    );

    always_comb begin
        cor = CR'(signed'({1'b0, cd_head})) +
              CR'(r_cfg.heading_offset_deg) * CR'(100);
        priority if (cor < 0) begin
            cor_wrap = cor + CR'(tch_pkg::DEG_360);
        end else if (cor > CR'(tch_pkg::DEG_360)) begin
            cor_wrap = cor - CR'(tch_pkg::DEG_360);
        end else begin
            cor_wrap = cor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= cd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.heading_raw       <= cd_head;
        r_res.heading_corrected <= cd_degen ? '0 : cor_wrap[tch_pkg::HEADING_W-1:0];
        r_res.degenerate        <= cd_degen;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== bench/tilt_compensated_heading_test.sv =====
// Self-checking testbench for the tilt-compensated heading block.
module tilt_compensated_heading_test;

    typedef struct {
        tch_pkg::t_in_item  sample;
        bit                 known;
        tch_pkg::t_out_item res;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    tch_pkg::t_in_item             i_item = '0;
    logic                          o_done;
    tch_pkg::t_out_item            o_result;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [tch_pkg::PADDR_W-1:0]   paddr = '0;
    logic [tch_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [tch_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    tch_pkg::t_cfg      cfg_model;
    tch_pkg::t_out_item heading_queue[$];
    t_row               rows[$];
    int                 errors = 0;
    bit                 steady = 1'b0;

    tilt_compensated_heading dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint shr0(longint v, int k);
        longint unsigned s;
        s = mag(v) >> k;
        return v < 0 ? -longint'(s) : longint'(s);
    endfunction

    // shift that brings the largest magnitude below 2^b
    function automatic int shift_for(longint x, longint y, longint z, int b);
        longint unsigned mx;
        int k;
        mx = mag(x);
        k = 0;
        if (mag(y) > mx) mx = mag(y);
        if (mag(z) > mx) mx = mag(z);
        while ((mx >> k) >= (64'd1 << b)) k++;
        return k;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int atan_step(int i);
        int t[20] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                      5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};
        return t[i];
    endfunction

    // angle of (x, y) in hundredths of a degree
    function automatic int angle_of(longint x, longint y);
        longint z, nx, ny;
        int k;
        z = 0;
        if (y == 0) return x < 0 ? tch_pkg::DEG_180 : 0;
        k = shift_for(x, y, 0, tch_pkg::XYR_B);
        x = shr0(x, k);
        y = shr0(y, k);
        if (x < 0) begin
            x = -x;
            y = -y;
            z = tch_pkg::Z_180;
        end
        for (int i = 0; i < tch_pkg::CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + shr0(y, i);
                ny = y - shr0(x, i);
                z += atan_step(i);
            end else begin
                nx = x - shr0(y, i);
                ny = y + shr0(x, i);
                z -= atan_step(i);
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z += tch_pkg::Z_360;
        return int'((z + 128) >>> 8);
    endfunction

    function automatic tch_pkg::t_out_item predict_heading(tch_pkg::t_in_item s);
        longint mx, my, mz, ax, ay, az, ex, ey, ez, xv, yv, cor;
        longint unsigned asq, q;
        int k, raw;
        tch_pkg::t_out_item r;
        mx = 2 * longint'(s.field_x) - (longint'(cfg_model.mag_min_x) + cfg_model.mag_max_x);
        my = 2 * longint'(s.field_y) - (longint'(cfg_model.mag_min_y) + cfg_model.mag_max_y);
        mz = 2 * longint'(s.field_z) - (longint'(cfg_model.mag_min_z) + cfg_model.mag_max_z);
        k = shift_for(mx, my, mz, tch_pkg::RED_B);
        mx = shr0(mx, k); my = shr0(my, k); mz = shr0(mz, k);
        ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
        ex = my * az - mz * ay;
        ey = mz * ax - mx * az;
        ez = mx * ay - my * ax;
        r = '0;
        if (ex == 0 && ey == 0 && ez == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        k = shift_for(ex, ey, ez, tch_pkg::ER_B);
        ex = shr0(ex, k); ey = shr0(ey, k); ez = shr0(ez, k);
        asq = ax * ax + ay * ay + az * az;
        q = int_sqrt(asq << 16);
        yv = (az * ex - ax * ez) * 256;
        xv = longint'(q) * ey;
        raw = angle_of(xv, yv);
        cor = raw + longint'(cfg_model.heading_offset_deg) * 100;
        if (cor < 0) cor += tch_pkg::DEG_360;
        else if (cor > tch_pkg::DEG_360) cor -= tch_pkg::DEG_360;
        r.heading_raw = raw[15:0];
        r.heading_corrected = cor[15:0];
        return r;
    endfunction

    task automatic write_reg(tch_pkg::t_reg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= tch_pkg::PADDR_W'(4 * int'(idx)); pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            tch_pkg::REG_MAG_MIN_X:      cfg_model.mag_min_x = v[15:0];
            tch_pkg::REG_MAG_MIN_Y:      cfg_model.mag_min_y = v[15:0];
            tch_pkg::REG_MAG_MIN_Z:      cfg_model.mag_min_z = v[15:0];
            tch_pkg::REG_MAG_MAX_X:      cfg_model.mag_max_x = v[15:0];
            tch_pkg::REG_MAG_MAX_Y:      cfg_model.mag_max_y = v[15:0];
            tch_pkg::REG_MAG_MAX_Z:      cfg_model.mag_max_z = v[15:0];
            tch_pkg::REG_HEADING_OFFSET: cfg_model.heading_offset_deg = v[8:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] lo, logic [15:0] hi, logic [8:0] offs, bit rnd);
        write_reg(tch_pkg::REG_MAG_MIN_X, rnd ? 32'($urandom) : {16'hffff, lo});
        write_reg(tch_pkg::REG_MAG_MIN_Y, rnd ? 32'($urandom) : {16'hffff, lo});
        write_reg(tch_pkg::REG_MAG_MIN_Z, rnd ? 32'($urandom) : {16'hffff, lo});
        write_reg(tch_pkg::REG_MAG_MAX_X, rnd ? 32'($urandom) : {16'h0, hi});
        write_reg(tch_pkg::REG_MAG_MAX_Y, rnd ? 32'($urandom) : {16'h0, hi});
        write_reg(tch_pkg::REG_MAG_MAX_Z, rnd ? 32'($urandom) : {16'h0, hi});
        write_reg(tch_pkg::REG_HEADING_OFFSET, {23'h0, offs});
    endtask

    task automatic send_sample(tch_pkg::t_in_item s, bit known, tch_pkg::t_out_item kres);
        // random gaps before about a fifth of the items unless steady is set
        if (!steady && $urandom_range(99) < 21) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= s;
        do @(posedge i_clk); while (busy);
        heading_queue.push_back(known ? kres : predict_heading(s));
    endtask

    function automatic tch_pkg::t_in_item rand_sample();
        tch_pkg::t_in_item s;
        s = tch_pkg::t_in_item'({$urandom, $urandom, $urandom});
        // mostly full-scale, sometimes small or near-degenerate vectors
        case ($urandom_range(9))
            0: s = tch_pkg::t_in_item'({6{16'($signed($urandom_range(0, 40)) - 20)}});
            1: begin
                s.accel_x = s.field_x; s.accel_y = s.field_y; s.accel_z = s.field_z;
            end
            2: begin
                s.accel_x = 16'($signed($urandom_range(0, 2000)) - 1000);
                s.accel_y = 16'($signed($urandom_range(0, 2000)) - 1000);
                s.accel_z = 16'($urandom_range(8000, 17000));
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic drain();
        start <= 1'b0;
        while (heading_queue.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic add_row(logic [15:0] fx, fy, fz, axv, ayv, azv, bit known);
        t_row r;
        r.sample = {fx, fy, fz, axv, ayv, azv};
        r.known = known;
        r.res = '0;
        r.res.degenerate = known;
        rows.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (heading_queue.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                errors++;
            end else begin
                if (o_result.heading_raw !== heading_queue[0].heading_raw ||
                    o_result.heading_corrected !== heading_queue[0].heading_corrected ||
                    o_result.degenerate !== heading_queue[0].degenerate) begin
                    $display("%0t: expected %p actual %p", $time, heading_queue[0], o_result);
                    errors++;
                end
                void'(heading_queue.pop_front());
            end
        end
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        cfg_model = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero, parallel and zero-length vectors give no east vector
        add_row(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1);
        add_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
        add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
        add_row(16'd1234, 16'hfb00, 16'd77, 16'h0, 16'h0, 16'h0, 1);
        add_row(16'h0, 16'h0, 16'h0, 16'd300, 16'h8000, 16'h7fff, 1);
        // Y zero with X negative, X positive; X zero
        add_row(16'd100, 16'h0, 16'h0, 16'h0, 16'h0, 16'd1000, 0);
        add_row(-16'sd100, 16'h0, 16'h0, 16'h0, 16'h0, 16'd1000, 0);
        add_row(16'h0, 16'd1000, 16'h0, 16'h0, 16'h0, 16'd1000, 0);
        add_row(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
        add_row(16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h8000, 16'h7fff, 0);
        add_row(16'd1, 16'h0, 16'h0, 16'h0, 16'd1, 16'h0, 0);
        add_row(16'd300, -16'sd200, 16'd50, 16'd100, -16'sd50, 16'd16000, 0);
        add_row(-16'sd300, 16'd250, -16'sd80, -16'sd900, 16'd400, 16'd15000, 0);
        add_row(16'd20, 16'd400, -16'sd600, 16'd16000, 16'd10, 16'd300, 0);
        add_row(16'h7fff, 16'h7fff, 16'h8000, 16'h1, 16'hffff, 16'h1, 0);
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].res);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_all(16'h8000, 16'h7fff, 9'd180, 0);
                1: write_all(16'h7fff, 16'h8000, -9'sd180, 0);
                2: write_all(16'h0, 16'h0, 9'h100, 1);
                3: write_all(16'h0, 16'h0, 9'h0ff, 1);
                default: write_all(16'h0, 16'h0, 9'($signed($urandom_range(0, 360)) - 180), 1);
            endcase
            // the directed extremes again under the new calibration
            foreach (rows[i]) send_sample(rows[i].sample, 0, '0);
            steady = (phase == 2);
            for (int n = 0; n < 185; n++) send_sample(rand_sample(), 0, '0);
            steady = 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
